[rtl/double_ended_queue_unit_macros.svh]
// Assertion macros for the double ended queue unit.
`ifndef DOUBLE_ENDED_QUEUE_UNIT_MACROS_SVH
`define DOUBLE_ENDED_QUEUE_UNIT_MACROS_SVH
`ifndef SYNTH
// Same-cycle implication, clocked on clk, idle during reset.
`define DEQ_ASSERT_IMP(lbl, a, b) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
    else $error("deque check failed");
// Next-cycle implication, clocked on clk, idle during reset.
`define DEQ_ASSERT_NXT(lbl, a, b) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
    else $error("deque check failed");
`else
`define DEQ_ASSERT_IMP(lbl, a, b)
`define DEQ_ASSERT_NXT(lbl, a, b)
`endif
`endif

[rtl/deq_pkg.sv]
// Shared types and codes for the double ended queue unit.
package deq_pkg;

  localparam int unsigned VALUE_W = 32;

  typedef enum logic [2:0] {
    CMD_PUSH_FRONT = 3'd0,
    CMD_PUSH_BACK  = 3'd1,
    CMD_POP_FRONT  = 3'd2,
    CMD_POP_BACK   = 3'd3,
    CMD_PEEK_FRONT = 3'd4,
    CMD_PEEK_BACK  = 3'd5,
    CMD_CLEAR      = 3'd6
  } deq_cmd_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_VALUE = 2'd1,
    ST_EMPTY = 2'd2,
    ST_FULL  = 2'd3
  } deq_status_t;

  // Per-beat controls broadcast to every cell.
  typedef struct packed {
    logic push_front;
    logic push_back;
    logic pop_front;
    logic rd_front;
    logic rd_back;
  } deq_ctrl_t;

endpackage

[rtl/deq_cell.sv]
// One storage cell of the shifting deque row.
module deq_cell #(
  parameter int unsigned IDX        = 0,
  parameter int unsigned CW         = 5,
  parameter int unsigned DATA_WIDTH = 32
) (
  input  logic                  clk,
  input  deq_pkg::deq_ctrl_t    ctrl,
  input  logic [CW-1:0]         count,
  input  logic [DATA_WIDTH-1:0] wdata,
  input  logic [DATA_WIDTH-1:0] left_data,
  input  logic [DATA_WIDTH-1:0] right_data,
  output logic [DATA_WIDTH-1:0] data_o,
  output logic [DATA_WIDTH-1:0] rd_o
);

  logic [DATA_WIDTH-1:0] data_r;
  logic [DATA_WIDTH-1:0] data_nxt;
  logic                  is_tail;
  logic                  is_last;
  logic                  sel;

  // Tail slot is where a back push lands; last slot holds the back entry.
  assign is_tail = (count == CW'(IDX));
  assign is_last = (count == CW'(IDX + 1));

  always_comb begin
    data_nxt = data_r;
    if (ctrl.push_front) begin
      data_nxt = left_data;
    end else if (ctrl.pop_front) begin
      data_nxt = right_data;
    end else if (ctrl.push_back && is_tail) begin
      data_nxt = wdata;
    end
  end

  always_ff @(posedge clk) begin
    data_r <= data_nxt;
  end

  assign sel    = (ctrl.rd_front && (IDX == 0)) || (ctrl.rd_back && is_last);
  assign data_o = data_r;
  assign rd_o   = sel ? data_r : '0;

endmodule

[rtl/double_ended_queue_unit.sv]
// Top level of the double ended queue unit: command decode, cell row, result register.
//
// Usage:
//   Drive a command on in_cmd / in_value and raise start. The beat is taken at
//   any rising edge where start is high and busy is low; busy is always low, so
//   one command per cycle is sustained (throughput 1 beat per cycle).
//   Every command yields exactly one registered result beat, in the next cycle, on
//   out_status / out_value_out / out_count, marked by out_valid for exactly
//   one cycle. The receiver cannot stall; results must be taken as they come.
//   Entries live in a row of DEPTH cells, front in cell 0. A front push shifts
//   the row toward the back, a front pop shifts it toward the front, a back
//   push writes the cell at the current count. The back read selects one cell
//   by its index compare and ORs the row together.
//   Push on a full queue reports full, pop or peek on an empty one reports
//   empty; neither changes the queue. Clear empties the queue in one beat.
//   Reset (rst_n low, synchronous) empties the queue and drops any pending
//   result; cell contents are not cleared and are never read before written.
module double_ended_queue_unit #(
  parameter int unsigned DEPTH      = 16,
  parameter int unsigned DATA_WIDTH = 32
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  output logic                        busy,
  input  logic [2:0]                  in_cmd,
  input  logic [deq_pkg::VALUE_W-1:0] in_value,
  output logic                        out_valid,
  output logic [1:0]                  out_status,
  output logic [deq_pkg::VALUE_W-1:0] out_value_out,
  output logic [$clog2(DEPTH + 1)-1:0] out_count
);

`include "double_ended_queue_unit_macros.svh"

  localparam int unsigned CW = $clog2(DEPTH + 1);

  // Occupancy and result registers.
  logic [CW-1:0]               count_r;
  logic [CW-1:0]               count_nxt;
  logic                        valid_r;
  logic [1:0]                  status_r;
  logic [1:0]                  status_nxt;
  logic [deq_pkg::VALUE_W-1:0] value_r;
  logic [CW-1:0]               res_count_r;

  logic                        accept;
  logic                        full;
  logic                        empty;
  deq_pkg::deq_ctrl_t          ctrl;
  logic [DATA_WIDTH-1:0]       wdata;
  logic [DATA_WIDTH-1:0]       cell_data [DEPTH];
  logic [DATA_WIDTH-1:0]       cell_rd   [DEPTH];
  logic [DATA_WIDTH-1:0]       rd_word;

  // No command keeps the block occupied, so never hold off the sender.
  assign busy   = 1'b0;
  assign accept = start && !busy;
  assign full   = (count_r == CW'(DEPTH));
  assign empty  = (count_r == '0);

  // Keep the low DATA_WIDTH bits of the pushed word.
  assign wdata = DATA_WIDTH'(in_value);

  // Decode the command into cell controls, next count and status.
  always_comb begin
    ctrl       = '0;
    count_nxt  = count_r;
    status_nxt = deq_pkg::ST_OK;
    if (accept) begin
      unique case (deq_pkg::deq_cmd_t'(in_cmd))
        deq_pkg::CMD_PUSH_FRONT, deq_pkg::CMD_PUSH_BACK: begin
          if (full) begin
            status_nxt = deq_pkg::ST_FULL;
          end else begin
            ctrl.push_front = (in_cmd == deq_pkg::CMD_PUSH_FRONT);
            ctrl.push_back  = (in_cmd == deq_pkg::CMD_PUSH_BACK);
            count_nxt       = count_r + CW'(1);
          end
        end
        deq_pkg::CMD_POP_FRONT, deq_pkg::CMD_POP_BACK,
        deq_pkg::CMD_PEEK_FRONT, deq_pkg::CMD_PEEK_BACK: begin
          if (empty) begin
            status_nxt = deq_pkg::ST_EMPTY;
          end else begin
            status_nxt     = deq_pkg::ST_VALUE;
            ctrl.rd_front  = (in_cmd == deq_pkg::CMD_POP_FRONT) ||
                             (in_cmd == deq_pkg::CMD_PEEK_FRONT);
            ctrl.rd_back   = (in_cmd == deq_pkg::CMD_POP_BACK) ||
                             (in_cmd == deq_pkg::CMD_PEEK_BACK);
            ctrl.pop_front = (in_cmd == deq_pkg::CMD_POP_FRONT);
            if ((in_cmd == deq_pkg::CMD_POP_FRONT) || (in_cmd == deq_pkg::CMD_POP_BACK)) begin
              count_nxt = count_r - CW'(1);
            end
          end
        end
        deq_pkg::CMD_CLEAR: begin
          count_nxt = '0;
        end
        default: begin
          // Unused code: leave the queue alone, report ok.
        end
      endcase
    end
  end

  // Row of cells: data moves one cell per beat on front push and pop.
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic [DATA_WIDTH-1:0] left_d;
    logic [DATA_WIDTH-1:0] right_d;
    if (i == 0) begin : g_first
      assign left_d = wdata;
    end else begin : g_mid
      assign left_d = cell_data[i-1];
    end
    if (i == DEPTH - 1) begin : g_last
      assign right_d = cell_data[i];
    end else begin : g_inner
      assign right_d = cell_data[i+1];
    end
    deq_cell #(
      .IDX       (i),
      .CW        (CW),
      .DATA_WIDTH(DATA_WIDTH)
    ) u_cell (
      .clk       (clk),
      .ctrl      (ctrl),
      .count     (count_r),
      .wdata     (wdata),
      .left_data (left_d),
      .right_data(right_d),
      .data_o    (cell_data[i]),
      .rd_o      (cell_rd[i])
    );
  end

  // At most one cell drives its read tap; merge the row.
  always_comb begin
    rd_word = '0;
    for (int i = 0; i < DEPTH; i++) begin
      rd_word = rd_word | cell_rd[i];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
      valid_r <= 1'b0;
    end else begin
      count_r <= count_nxt;
      valid_r <= accept;
    end
  end

  // Result payload: capture alongside the strobe.
  always_ff @(posedge clk) begin
    status_r    <= status_nxt;
    value_r     <= deq_pkg::VALUE_W'(rd_word);
    res_count_r <= count_nxt;
  end

  assign out_valid     = valid_r;
  assign out_status    = status_r;
  assign out_value_out = value_r;
  assign out_count     = res_count_r;

  // Every accepted command gives a result on the next cycle, and only then.
  `DEQ_ASSERT_NXT(a_beat_result, accept, out_valid)
  `DEQ_ASSERT_NXT(a_no_stray_result, !accept, !out_valid)
  // Occupancy never exceeds the row length.
  `DEQ_ASSERT_IMP(a_count_bound, 1'b1, count_r <= CW'(DEPTH))
  // Non-value results carry a zero word.
  `DEQ_ASSERT_IMP(a_zero_word, out_valid && (out_status != deq_pkg::ST_VALUE),
                  out_value_out == '0)

endmodule

[test/double_ended_queue_unit_test.sv]
// Self-checking testbench for the double ended queue unit: directed table, then random traffic.
`timescale 1ns / 100ps

module double_ended_queue_unit_test;

  localparam int unsigned DEPTH = 16;
  localparam int unsigned WORD_W = deq_pkg::VALUE_W;
  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam int RANDOM_BEATS = 1200;
  localparam int CYCLE_LIMIT = 200000;
  localparam int REPORT_LIMIT = 10;
  localparam int GAP_PERCENT = 24;
  // Command code the block has no meaning for; it must answer ok and change nothing.
  localparam logic [2:0] CMD_UNUSED = 3'd7;

  // One result beat as the block should present it.
  typedef struct packed {
    deq_pkg::deq_status_t status;
    logic [WORD_W-1:0]    word;
    logic [CW-1:0]        count;
  } deque_result_t;

  // One row of the directed table. Rows with want_typed set carry a hand-written
  // result; the rest are checked against the running deque model below.
  typedef struct {
    logic [2:0]        cmd;
    logic [WORD_W-1:0] word;
    bit                rand_word;
    int                reps;
    bit                want_typed;
    deque_result_t     want;
  } stim_row_t;

  localparam deque_result_t NO_WANT = '{deq_pkg::ST_OK, '0, '0};
  localparam int DIR_ROWS = 15;

  logic              clk;
  logic              rst_n;
  logic              start;
  logic              busy;
  logic [2:0]        in_cmd;
  logic [WORD_W-1:0] in_value;
  logic              out_valid;
  logic [1:0]        out_status;
  logic [WORD_W-1:0] out_value_out;
  logic [CW-1:0]     out_count;

  double_ended_queue_unit dut (
    .clk          (clk),
    .rst_n        (rst_n),
    .start        (start),
    .busy         (busy),
    .in_cmd       (in_cmd),
    .in_value     (in_value),
    .out_valid    (out_valid),
    .out_status   (out_status),
    .out_value_out(out_value_out),
    .out_count    (out_count)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Deque model state: ring of words, front slot and number of entries held.
  // The 4-bit front slot wraps on its own since the ring is 16 deep.
  logic [WORD_W-1:0] ring [DEPTH];
  logic [3:0]        front_slot = '0;
  logic [CW-1:0]     held = '0;

  // Results still owed by the block, oldest first.
  deque_result_t pending_results [$];

  // Side channel from the sender: a hand-written result that travels with the beat.
  bit            beat_typed;
  deque_result_t beat_want;

  bit gaps_enabled;
  int fault_count = 0;
  int cycle_count = 0;

  stim_row_t dir_tab [DIR_ROWS];

  // Apply one command to the model and return the result it yields.
  function automatic deque_result_t apply_deque_cmd(logic [2:0] cmd,
                                                    logic [WORD_W-1:0] word);
    deque_result_t r;
    logic [3:0]    slot;
    r = NO_WANT;
    case (cmd)
      deq_pkg::CMD_PUSH_FRONT, deq_pkg::CMD_PUSH_BACK: begin
        if (held == DEPTH) begin
          r.status = deq_pkg::ST_FULL;
        end else begin
          if (cmd == deq_pkg::CMD_PUSH_FRONT) begin
            front_slot = front_slot - 4'd1;
            slot = front_slot;
          end else begin
            slot = front_slot + held[3:0];
          end
          ring[slot] = word;
          held = held + 1'b1;
        end
      end
      deq_pkg::CMD_POP_FRONT, deq_pkg::CMD_POP_BACK,
      deq_pkg::CMD_PEEK_FRONT, deq_pkg::CMD_PEEK_BACK: begin
        if (held == 0) begin
          r.status = deq_pkg::ST_EMPTY;
        end else begin
          if (cmd == deq_pkg::CMD_POP_FRONT || cmd == deq_pkg::CMD_PEEK_FRONT)
            slot = front_slot;
          else
            slot = front_slot + held[3:0] - 4'd1;
          r.status = deq_pkg::ST_VALUE;
          r.word = ring[slot];
          if (cmd == deq_pkg::CMD_POP_FRONT) begin
            front_slot = front_slot + 4'd1;
            held = held - 1'b1;
          end else if (cmd == deq_pkg::CMD_POP_BACK) begin
            held = held - 1'b1;
          end
        end
      end
      deq_pkg::CMD_CLEAR: begin
        front_slot = '0;
        held = '0;
      end
      default: ;
    endcase
    r.count = held;
    return r;
  endfunction

  // Monitor: on every edge first record what an accepted beat should produce,
  // then check the result beat that is on the outputs. Recording first keeps
  // the check correct even if the block answered within the same cycle.
  always @(posedge clk) begin
    deque_result_t predicted;
    deque_result_t want;
    cycle_count <= cycle_count + 1;
    if (rst_n) begin
      if (start && busy === 1'b0) begin
        predicted = apply_deque_cmd(in_cmd, in_value);
        pending_results.push_back(beat_typed ? beat_want : predicted);
      end
      if (out_valid === 1'b1) begin
        if (pending_results.size() == 0) begin
          fault_count <= fault_count + 1;
          if (fault_count < REPORT_LIMIT)
            $display("mismatch: result beat with none owed: status %0d word %h count %0d",
                     out_status, out_value_out, out_count);
        end else begin
          want = pending_results.pop_front();
          if (out_status !== want.status || out_value_out !== want.word ||
              out_count !== want.count) begin
            fault_count <= fault_count + 1;
            if (fault_count < REPORT_LIMIT)
              $display(
                "mismatch at cycle %0d: expected %0d %h %0d, got %0d %h %0d",
                cycle_count, want.status, want.word, want.count,
                out_status, out_value_out, out_count);
          end
        end
      end
    end
  end

  // Watchdog: a hung handshake or a missing result ends here.
  always @(posedge clk) begin
    if (cycle_count > CYCLE_LIMIT) begin
      $display("FAIL double_ended_queue_unit");
      $finish;
    end
  end

  // Offer one beat: idle a random number of cycles first (when gaps are on),
  // then hold start until the beat is taken at a rising edge with busy low.
  task automatic send_cmd(input logic [2:0] cmd, input logic [WORD_W-1:0] word,
                          input bit typed, input deque_result_t want);
    while (gaps_enabled && $urandom_range(99) < GAP_PERCENT) begin
      @(negedge clk);
      start <= 1'b0;
    end
    @(negedge clk);
    start      <= 1'b1;
    in_cmd     <= cmd;
    in_value   <= word;
    beat_typed <= typed;
    beat_want  <= want;
    do @(posedge clk); while (busy !== 1'b0);
  endtask

  // Drop start and hold off until every owed result has come back.
  task automatic drain_results();
    @(negedge clk);
    start <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  initial begin
    logic [2:0]        cmd;
    logic [WORD_W-1:0] word;
    int                roll;
    bit                filling;

    rst_n        = 1'b0;
    start        = 1'b0;
    in_cmd       = '0;
    in_value     = '0;
    beat_typed   = 1'b0;
    beat_want    = NO_WANT;
    gaps_enabled = 1'b1;
    filling      = 1'b1;

    // Directed table. Hand-written results only where they are obvious:
    // the empty queue, the all-zero and all-one words, the full refusals.
    dir_tab[0]  = '{deq_pkg::CMD_PEEK_FRONT, 32'h0, 1'b0, 1, 1'b1,
                    '{deq_pkg::ST_EMPTY, 32'h0, 5'd0}};
    dir_tab[1]  = '{deq_pkg::CMD_POP_BACK, 32'h0, 1'b0, 1, 1'b1,
                    '{deq_pkg::ST_EMPTY, 32'h0, 5'd0}};
    dir_tab[2]  = '{deq_pkg::CMD_PUSH_BACK, 32'hFFFF_FFFF, 1'b0, 1, 1'b1,
                    '{deq_pkg::ST_OK, 32'h0, 5'd1}};
    dir_tab[3]  = '{deq_pkg::CMD_PUSH_FRONT, 32'h0, 1'b0, 1, 1'b1,
                    '{deq_pkg::ST_OK, 32'h0, 5'd2}};
    dir_tab[4]  = '{deq_pkg::CMD_PEEK_FRONT, 32'h0, 1'b0, 1, 1'b1,
                    '{deq_pkg::ST_VALUE, 32'h0, 5'd2}};
    dir_tab[5]  = '{deq_pkg::CMD_PEEK_BACK, 32'h0, 1'b0, 1, 1'b1,
                    '{deq_pkg::ST_VALUE, 32'hFFFF_FFFF, 5'd2}};
    dir_tab[6]  = '{deq_pkg::CMD_POP_FRONT, 32'h0, 1'b0, 1, 1'b1,
                    '{deq_pkg::ST_VALUE, 32'h0, 5'd1}};
    // Fill to the top from both ends with random words.
    dir_tab[7]  = '{deq_pkg::CMD_PUSH_BACK, 32'h0, 1'b1, 7, 1'b0, NO_WANT};
    dir_tab[8]  = '{deq_pkg::CMD_PUSH_FRONT, 32'h0, 1'b1, 8, 1'b0, NO_WANT};
    // Full: both pushes refused, queue unchanged.
    dir_tab[9]  = '{deq_pkg::CMD_PUSH_FRONT, 32'h1234_5678, 1'b0, 1, 1'b1,
                    '{deq_pkg::ST_FULL, 32'h0, 5'd16}};
    dir_tab[10] = '{deq_pkg::CMD_PUSH_BACK, 32'hFFFF_FFFF, 1'b0, 1, 1'b1,
                    '{deq_pkg::ST_FULL, 32'h0, 5'd16}};
    dir_tab[11] = '{deq_pkg::CMD_PEEK_FRONT, 32'h0, 1'b0, 1, 1'b0, NO_WANT};
    dir_tab[12] = '{deq_pkg::CMD_CLEAR, 32'hA5A5_A5A5, 1'b0, 1, 1'b1,
                    '{deq_pkg::ST_OK, 32'h0, 5'd0}};
    dir_tab[13] = '{deq_pkg::CMD_POP_FRONT, 32'h0, 1'b0, 1, 1'b1,
                    '{deq_pkg::ST_EMPTY, 32'h0, 5'd0}};
    // Unused code: ignored, ok, nothing held.
    dir_tab[14] = '{CMD_UNUSED, 32'h5A5A_5A5A, 1'b0, 1, 1'b1,
                    '{deq_pkg::ST_OK, 32'h0, 5'd0}};

    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    foreach (dir_tab[i]) begin
      for (int r = 0; r < dir_tab[i].reps; r++) begin
        word = dir_tab[i].rand_word ? WORD_W'($urandom) : dir_tab[i].word;
        send_cmd(dir_tab[i].cmd, word, dir_tab[i].want_typed, dir_tab[i].want);
      end
    end

    // Hold the sender until the directed results are all in.
    drain_results();

    // Random traffic in fill and drain sweeps so the count runs the whole range,
    // hitting full refusals and empty errors along the way.
    for (int n = 0; n < RANDOM_BEATS; n++) begin
      // Run a long stretch back to back with no gaps.
      gaps_enabled = !(n >= 300 && n < 500);
      if (n == RANDOM_BEATS / 2) drain_results();

      if (held == DEPTH && $urandom_range(3) == 0) filling = 1'b0;
      if (held == 0 && $urandom_range(3) == 0) filling = 1'b1;

      roll = $urandom_range(99);
      if (roll < 2)
        cmd = deq_pkg::CMD_CLEAR;
      else if (roll < 3)
        cmd = CMD_UNUSED;
      else if (roll < 13)
        cmd = $urandom_range(1) ? deq_pkg::CMD_PEEK_BACK : deq_pkg::CMD_PEEK_FRONT;
      else if (roll < (filling ? 78 : 33))
        cmd = $urandom_range(1) ? deq_pkg::CMD_PUSH_BACK : deq_pkg::CMD_PUSH_FRONT;
      else
        cmd = $urandom_range(1) ? deq_pkg::CMD_POP_BACK : deq_pkg::CMD_POP_FRONT;

      roll = $urandom_range(9);
      if (roll == 0) word = '0;
      else if (roll == 1) word = '1;
      else word = WORD_W'($urandom);

      send_cmd(cmd, word, 1'b0, NO_WANT);
    end

    // Wait out the owed results, then keep the clock running to catch stray beats.
    drain_results();
    repeat (4) @(posedge clk);

    if (fault_count == 0 && pending_results.size() == 0) begin
      $display("PASS double_ended_queue_unit");
    end else begin
      $display("FAIL double_ended_queue_unit");
    end
    $finish;
  end

endmodule
